// File: rtl/core/sensor_level_lcd_formatter_macros.svh
// Assertion macros shared by the checker of the sensor level LCD formatter.
`ifndef SENSOR_LEVEL_LCD_FORMATTER_MACROS_SVH
`define SENSOR_LEVEL_LCD_FORMATTER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slf: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define SLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slf: next-cycle check failed");

`endif

// File: rtl/core/slf_pkg.sv
`timescale 1ns / 1ps
// Types, codes and constants of the sensor level LCD formatter.
package slf_pkg;

  localparam int DATA_W    = 8;
  localparam int COL_W     = 4;
  localparam int KIND_W    = 2;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SEL_W     = 4;
  localparam int BCD_W     = 4;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int MATCH_TOLERANCE_DEF = 2;
  localparam int BAR_STEP_DEF        = 4;
  localparam int BAR_COLUMNS_DEF     = 10;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REACT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_REACT = 3'd7;

  // reset values, index 0 at the right
  localparam logic [NUM_CFG-1:0][DATA_W-1:0] CFG_RESET = {
    8'd2, 8'd2, 8'd100, 8'd1, 8'd0, 8'd100, 8'd1, 8'd0
  };

  // display bytes
  localparam logic [DATA_W-1:0] CURSOR_TEMP  = 8'h8C;
  localparam logic [DATA_W-1:0] CURSOR_LIGHT = 8'hCD;
  localparam logic [DATA_W-1:0] CMD_DDRAM    = 8'h80;
  localparam logic [DATA_W-1:0] ROW2_OFS     = 8'h40;
  localparam logic [DATA_W-1:0] CHR_DEGREE   = 8'hDF;
  localparam logic [DATA_W-1:0] CHR_UPPER_C  = 8'h43;
  localparam logic [DATA_W-1:0] CHR_PERCENT  = 8'h25;
  localparam logic [DATA_W-1:0] CHR_SPACE    = 8'h20;
  localparam logic [DATA_W-1:0] CHR_ZERO     = 8'h30;
  localparam logic [COL_W-1:0]  COL_RESET    = 4'd1;

  // result selection codes
  localparam logic [SEL_W-1:0] SEL_CURSOR = 4'd0;
  localparam logic [SEL_W-1:0] SEL_REPORT = 4'd1;
  localparam logic [SEL_W-1:0] SEL_DIG_A  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_DIG_B  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_DIG_C  = 4'd4;
  localparam logic [SEL_W-1:0] SEL_SUF_A  = 4'd5;
  localparam logic [SEL_W-1:0] SEL_SUF_B  = 4'd6;
  localparam logic [SEL_W-1:0] SEL_BAR    = 4'd7;
  localparam logic [SEL_W-1:0] SEL_GLYPH  = 4'd8;

  typedef struct packed {
    logic              channel;
    logic [DATA_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] lcd_byte;
    logic              report_sensor;
    logic [DATA_W-1:0] report_level;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
  } cfg_item_t;

  typedef struct packed {
    logic             load;
    logic             probe;
    logic             scan_adv;
    logic             emit;
    logic [SEL_W-1:0] sel;
    logic             rep_upd;
    logic             bar_upd;
    logic             flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic near_tol;
    logic i_ge100;
    logic rep_any;
    logic glyph_ok;
    logic emit_ok;
    logic flush_ok;
  } dp_status_t;

endpackage

// File: rtl/core/slf_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per transfer.
interface slf_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/slf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the sensor level LCD formatter.
module slf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slf_pkg::dp_status_t st,
  output slf_pkg::ctrl_cmd_t  cmd
);
  import slf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CURSOR = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_REP    = 4'd3;
  localparam logic [3:0] S_DIG_A  = 4'd4;
  localparam logic [3:0] S_DIG_B  = 4'd5;
  localparam logic [3:0] S_DIG_C  = 4'd6;
  localparam logic [3:0] S_SUF_A  = 4'd7;
  localparam logic [3:0] S_SUF_B  = 4'd8;
  localparam logic [3:0] S_BAR    = 4'd9;
  localparam logic [3:0] S_GLYPH  = 4'd10;
  localparam logic [3:0] S_FLUSH  = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CURSOR;
        end
      end
      S_CURSOR: begin
        cmd.sel = SEL_CURSOR;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_end) begin
          state_nxt = S_BAR;
        end else begin
          cmd.probe = 1'b1;
          if (st.near_tol) state_nxt = S_REP;
          else cmd.scan_adv = 1'b1;
        end
      end
      S_REP: begin
        cmd.sel = SEL_REPORT;
        if (st.emit_ok) begin
          cmd.emit    = st.rep_any;
          cmd.rep_upd = 1'b1;
          state_nxt   = S_DIG_A;
        end
      end
      S_DIG_A: begin
        cmd.sel = SEL_DIG_A;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DIG_B;
        end
      end
      S_DIG_B: begin
        cmd.sel = SEL_DIG_B;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = st.i_ge100 ? S_DIG_C : S_SUF_A;
        end
      end
      S_DIG_C: begin
        cmd.sel = SEL_DIG_C;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_SUF_A;
        end
      end
      S_SUF_A: begin
        cmd.sel = SEL_SUF_A;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_SUF_B;
        end
      end
      S_SUF_B: begin
        cmd.sel = SEL_SUF_B;
        if (st.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_BAR: begin
        cmd.sel = SEL_BAR;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.bar_upd = 1'b1;
          state_nxt   = S_GLYPH;
        end
      end
      S_GLYPH: begin
        cmd.sel = SEL_GLYPH;
        if (st.emit_ok) begin
          cmd.emit  = st.glyph_ok;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (st.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: rtl/core/slf_dp.sv
`timescale 1ns / 1ps
// Datapath: registers, level scan, display state and result buffering.
module slf_dp #(
  parameter int MATCH_TOLERANCE = slf_pkg::MATCH_TOLERANCE_DEF,
  parameter int BAR_STEP        = slf_pkg::BAR_STEP_DEF,
  parameter int BAR_COLUMNS     = slf_pkg::BAR_COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slf_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  slf_pkg::cfg_item_t  cfg_item,
  input  slf_pkg::ctrl_cmd_t  cmd,
  output slf_pkg::dp_status_t st,
  input  logic                out_ready,
  output logic                out_valid,
  output slf_pkg::out_item_t  out_item
);
  import slf_pkg::*;

  localparam int SUB_W = (BAR_STEP > 1) ? $clog2(BAR_STEP) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(BAR_STEP - 1);
  localparam logic [3:0] GLYPHS = 4'd8;

  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [NUM_CFG-1:0][DATA_W-1:0] cfg_r;

  logic              ch_r;
  logic [DATA_W-1:0] sample_r;
  logic [DATA_W-1:0] v_r;
  logic [DATA_W-1:0] i_r;
  logic [BCD_W-1:0]  bcd_h_r, bcd_t_r, bcd_o_r;
  logic [SUB_W-1:0]  gsub_r;
  logic [3:0]        g_r;
  logic              found_r;
  logic [2:0]        first_g_r;
  logic              first_ok_r;

  logic [DATA_W-1:0] temp_level_r, light_level_r;
  logic [DATA_W-1:0] temp_rep_r, light_rep_r;
  logic [COL_W-1:0]  col_r [2];

  out_item_t         pend_r, out_r, pend_last, new_item;
  logic              pend_vld_r, out_vld_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [DATA_W-1:0] step_sel, limit_sel, diff;
  logic              near1, temp_chg, light_chg, i_ge10, emit_do;
  logic [COL_W-1:0]  col_cur, col_eff, col_m1;

  assign step_sel  = ch_r ? cfg_r[CFG_LIGHT_STEP] : cfg_r[CFG_TEMP_STEP];
  assign limit_sel = ch_r ? cfg_r[CFG_LIGHT_LIMIT] : cfg_r[CFG_TEMP_LIMIT];
  assign diff      = abs_diff(sample_r, v_r);
  assign near1     = (diff <= 8'd1);

  assign temp_chg  = abs_diff(temp_rep_r, temp_level_r) >= cfg_r[CFG_TEMP_REACT];
  assign light_chg = abs_diff(light_rep_r, light_level_r) >= cfg_r[CFG_LIGHT_REACT];

  assign i_ge10  = st.i_ge100 || (bcd_t_r != '0);

  assign col_cur = col_r[ch_r];
  assign col_eff = ((col_cur == '0) || (col_cur > COL_W'(BAR_COLUMNS))) ? COL_RESET : col_cur;
  assign col_m1  = col_eff - COL_RESET;

  assign st.scan_end = (i_r >= limit_sel);
  assign st.near_tol = (diff <= DATA_W'(MATCH_TOLERANCE));
  assign st.i_ge100  = (bcd_h_r != '0);
  assign st.rep_any  = temp_chg || light_chg;
  assign st.glyph_ok = found_r && first_ok_r;
  assign st.emit_ok  = !pend_vld_r || !out_vld_r || out_ready;
  assign st.flush_ok = !out_vld_r || out_ready;

  assign emit_do = cmd.emit && (cnt_r < CNT_W'(MAX_RESULTS));

  always_comb begin
    new_item = '0;
    unique case (cmd.sel)
      SEL_CURSOR: begin
        new_item.kind     = KIND_CMD;
        new_item.lcd_byte = ch_r ? CURSOR_LIGHT : CURSOR_TEMP;
      end
      SEL_REPORT: begin
        new_item.kind          = KIND_REPORT;
        new_item.report_sensor = !temp_chg;
        new_item.report_level  = temp_chg ? temp_level_r : light_level_r;
      end
      SEL_DIG_A: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = st.i_ge100 ? CHR_ZERO + {4'h0, bcd_h_r} :
                            i_ge10     ? CHR_ZERO + {4'h0, bcd_t_r} : CHR_SPACE;
      end
      SEL_DIG_B: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = CHR_ZERO + {4'h0, (st.i_ge100 ? bcd_t_r : bcd_o_r)};
      end
      SEL_DIG_C: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = CHR_ZERO + {4'h0, bcd_o_r};
      end
      SEL_SUF_A: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = ch_r ? CHR_PERCENT : CHR_DEGREE;
      end
      SEL_SUF_B: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = ch_r ? CHR_SPACE : CHR_UPPER_C;
      end
      SEL_BAR: begin
        new_item.kind     = KIND_CMD;
        new_item.lcd_byte = CMD_DDRAM + (ch_r ? ROW2_OFS : 8'h00) + {4'h0, col_m1};
      end
      SEL_GLYPH: begin
        new_item.kind     = KIND_CHAR;
        new_item.lcd_byte = {5'h00, first_g_r};
      end
      default: new_item = '0;
    endcase
  end

  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  // configuration and persistent display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= CFG_RESET;
      temp_level_r  <= '0;
      light_level_r <= '0;
      temp_rep_r    <= '0;
      light_rep_r   <= '0;
      col_r[0]      <= COL_RESET;
      col_r[1]      <= COL_RESET;
    end else begin
      if (cfg_we) cfg_r[cfg_item.index] <= cfg_item.value;
      if (cmd.rep_upd) begin
        if (temp_chg) temp_rep_r <= temp_level_r;
        else if (light_chg) light_rep_r <= light_level_r;
        if (ch_r) light_level_r <= i_r;
        else temp_level_r <= i_r;
      end
      if (cmd.bar_upd) col_r[ch_r] <= col_eff + COL_RESET;
    end
  end

  // level scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_item.channel;
      sample_r <= in_item.sample;
      v_r      <= in_item.channel ? cfg_r[CFG_LIGHT_BASE] : cfg_r[CFG_TEMP_BASE];
      i_r      <= '0;
      bcd_h_r  <= '0;
      bcd_t_r  <= '0;
      bcd_o_r  <= '0;
      gsub_r   <= '0;
      g_r      <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.probe && !found_r && near1) begin
        found_r    <= 1'b1;
        first_g_r  <= g_r[2:0];
        first_ok_r <= !g_r[3];
      end
      if (cmd.scan_adv) begin
        v_r <= v_r + step_sel;
        i_r <= i_r + 8'd1;
        if (bcd_o_r == 4'd9) begin
          bcd_o_r <= '0;
          if (bcd_t_r == 4'd9) begin
            bcd_t_r <= '0;
            bcd_h_r <= bcd_h_r + 4'd1;
          end else begin
            bcd_t_r <= bcd_t_r + 4'd1;
          end
        end else begin
          bcd_o_r <= bcd_o_r + 4'd1;
        end
        if (gsub_r == SUB_LAST) begin
          gsub_r <= '0;
          if (g_r != GLYPHS) g_r <= g_r + 4'd1;
        end else begin
          gsub_r <= gsub_r + SUB_W'(1);
        end
      end
    end
  end

  // one result held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cmd.load) cnt_r <= '0;
      else if (emit_do) cnt_r <= cnt_r + CNT_W'(1);

      if (cmd.flush) pend_vld_r <= 1'b0;
      else if (emit_do) pend_vld_r <= 1'b1;

      if (cmd.flush || (emit_do && pend_vld_r)) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) out_r <= pend_last;
    else if (emit_do && pend_vld_r) out_r <= pend_r;
    if (emit_do) pend_r <= new_item;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

// File: rtl/core/sensor_level_lcd_formatter.sv
`timescale 1ns / 1ps
// Top level of the sensor level LCD formatter.
// Usage:
//   in_chan  takes one transfer per reading: channel (0 temperature, 1 light)
//            and the 8-bit sample. in_chan.ready is high only while idle.
//   out_chan gives the resulting items in order: cursor command, per matching
//            level an optional change report plus digit and suffix characters,
//            then the bar cursor command and an optional bar glyph; last marks
//            the final item of the reading. At most 64 items per reading.
//   cfg_chan is always ready; write registers only while idle.
// Timing: a reading passes the cursor, scan, bar, glyph and flush steps, plus
//   report, digit and suffix steps per matching level (a third digit from 100
//   up); the scan visits one non-matching index per cycle. The first item is
//   formed in the cycle after the transfer and shows on out_chan once the
//   second is formed; the final item enters the output register on flush.
// Stalls: one result is held back and one sits in the output register; when
//   out_chan.ready is low the sequencer waits, nothing is dropped. The next
//   reading is taken while the final item still waits in the output register.
// Reset: registers return to their defaults, levels and reports to zero,
//   bar columns to one; no clearing pass is needed.
module sensor_level_lcd_formatter #(
  parameter int MATCH_TOLERANCE = slf_pkg::MATCH_TOLERANCE_DEF,
  parameter int BAR_STEP        = slf_pkg::BAR_STEP_DEF,
  parameter int BAR_COLUMNS     = slf_pkg::BAR_COLUMNS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  slf_chan_if.sink   in_chan,
  slf_chan_if.source out_chan,
  slf_chan_if.sink   cfg_chan
);
  import slf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  slf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  slf_dp #(
    .MATCH_TOLERANCE (MATCH_TOLERANCE),
    .BAR_STEP        (BAR_STEP),
    .BAR_COLUMNS     (BAR_COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_chan.data),
    .cfg_we    (cfg_chan.valid),
    .cfg_item  (cfg_chan.data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_item  (out_chan.data)
  );

endmodule

// File: rtl/core/slf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the sensor level LCD formatter, bound to the top level.
`include "sensor_level_lcd_formatter_macros.svh"

module slf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input slf_pkg::out_item_t out_item
);
  import slf_pkg::*;

  `SLF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
  `SLF_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `SLF_ASSERT_IMP(a_kind_known, clk, rst_n, out_valid, out_item.kind == KIND_CMD || out_item.kind == KIND_CHAR || out_item.kind == KIND_REPORT)
  `SLF_ASSERT_IMP(a_unused_zero, clk, rst_n, out_valid && out_item.kind != KIND_REPORT, out_item.report_sensor == 1'b0 && out_item.report_level == '0)

endmodule

bind sensor_level_lcd_formatter slf_checker u_slf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.data)
);
